@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is not checked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("ps2 sequencer assertion failed");

// Clocked property that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ps2 sequencer assertion failed");

`endif

@@ rtl/ps2cas_pkg.sv @@
package ps2cas_pkg;

    // Default timing and retry limits.
    localparam int ACK_TIMEOUT_MS_DEF       = 100;
    localparam int RESET_ACK_TIMEOUT_MS_DEF = 500;
    localparam int SELFTEST_TIMEOUT_MS_DEF  = 1000;
    localparam int MAX_RESENDS_DEF          = 5;

    // Millisecond counter saturates at its full range.
    localparam int ELAPSED_W = 10;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam int RESENDS_W = 3;

    // Result queue depth: two items worth of results.
    localparam int RESQ_DEPTH = 4;

    // Request kinds.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Operations.
    localparam logic [1:0] OP_DISABLE = 2'd0;
    localparam logic [1:0] OP_ENABLE  = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Device ports.
    localparam logic [1:0] PORT_ONE = 2'd1;
    localparam logic [1:0] PORT_TWO = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DIS1     = 3'd1,
        PH_EN       = 3'd2,
        PH_RST      = 3'd3,
        PH_SELFTEST = 3'd4,
        PH_DIS2     = 3'd5,
        PH_DRAIN    = 3'd6,
        PH_DIS3     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ACT_CMD  = 2'd0,
        ACT_DATA = 2'd1,
        ACT_DONE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_NODEV   = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_ACK      = 3'd0,
        REG_RESEND   = 3'd1,
        REG_STOK     = 3'd2,
        REG_PREFIX   = 3'd3,
        REG_DISABLE  = 3'd4,
        REG_ENABLE   = 3'd5,
        REG_RESETCMD = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] ack_code;
        logic [7:0] resend_code;
        logic [7:0] selftest_ok_code;
        logic [7:0] second_port_prefix;
        logic [7:0] disable_scan_cmd;
        logic [7:0] enable_scan_cmd;
        logic [7:0] reset_selftest_cmd;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic [7:0] out_byte;
        t_status    status;
        logic       final_disable_failed;
        logic       last;
    } t_res;

endpackage

@@ rtl/ps2_command_ack_sequencer_unit.sv @@
// Channel  Dir  Handshake                  Fields
// in       in   i_in_valid / o_in_stall    req_type, operation, port_number, rx_byte
// out      out  o_out_valid / i_out_stall  action, out_byte, status, final_disable_failed, last
// cfg      in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One input word is taken per cycle while not stalled, handled in that cycle; its results
// enter the result queue at the accepting edge and are offered from the next cycle on.
// A word causes zero, one or two results; the queue drains one result per unstalled cycle.
// The four-entry result queue sets the stall: input stalls while fewer than two slots are free.
// Reset is synchronous and active low; it restores the default register values and idles.
module ps2_command_ack_sequencer_unit #(
    parameter int ACK_TIMEOUT_MS       = ps2cas_pkg::ACK_TIMEOUT_MS_DEF,
    parameter int RESET_ACK_TIMEOUT_MS = ps2cas_pkg::RESET_ACK_TIMEOUT_MS_DEF,
    parameter int SELFTEST_TIMEOUT_MS  = ps2cas_pkg::SELFTEST_TIMEOUT_MS_DEF,
    parameter int MAX_RESENDS          = ps2cas_pkg::MAX_RESENDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [1:0] i_operation,
    input  logic [1:0] i_port_number,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_action,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_final_disable_failed,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    ps2cas_pkg::t_cfg cfg;
    ps2cas_pkg::t_res res0, res1, head;
    logic [1:0]       res_cnt;
    logic             accept;

    assign accept = i_in_valid && !o_in_stall;

    // Configuration registers.
    ps2cas_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Command sequencer.
    ps2cas_step #(
        .ACK_TIMEOUT_MS       (ACK_TIMEOUT_MS),
        .RESET_ACK_TIMEOUT_MS (RESET_ACK_TIMEOUT_MS),
        .SELFTEST_TIMEOUT_MS  (SELFTEST_TIMEOUT_MS),
        .MAX_RESENDS          (MAX_RESENDS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_req_type),
        .i_operation   (i_operation),
        .i_port_number (i_port_number),
        .i_rx_byte     (i_rx_byte),
        .i_cfg         (cfg),
        .o_res0        (res0),
        .o_res1        (res1),
        .o_res_cnt     (res_cnt)
    );

    // Result queue.
    ps2cas_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (res_cnt),
        .i_push0    (res0),
        .i_push1    (res1),
        .i_pop      (!i_out_stall),
        .o_head     (head),
        .o_valid    (o_out_valid),
        .o_stall    (o_in_stall)
    );

    assign o_action               = 2'(head.action);
    assign o_out_byte             = head.out_byte;
    assign o_status               = 2'(head.status);
    assign o_final_disable_failed = head.final_disable_failed;
    assign o_last                 = head.last;

endmodule

@@ rtl/ps2cas_regs.sv @@
module ps2cas_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    output ps2cas_pkg::t_cfg   o_cfg
);

    ps2cas_pkg::t_cfg r_cfg;

    // Register file with protocol defaults after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_code           <= 8'd250;
            r_cfg.resend_code        <= 8'd254;
            r_cfg.selftest_ok_code   <= 8'd170;
            r_cfg.second_port_prefix <= 8'd212;
            r_cfg.disable_scan_cmd   <= 8'd245;
            r_cfg.enable_scan_cmd    <= 8'd244;
            r_cfg.reset_selftest_cmd <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ps2cas_pkg::REG_ACK:      r_cfg.ack_code           <= i_cfg_data;
                ps2cas_pkg::REG_RESEND:   r_cfg.resend_code        <= i_cfg_data;
                ps2cas_pkg::REG_STOK:     r_cfg.selftest_ok_code   <= i_cfg_data;
                ps2cas_pkg::REG_PREFIX:   r_cfg.second_port_prefix <= i_cfg_data;
                ps2cas_pkg::REG_DISABLE:  r_cfg.disable_scan_cmd   <= i_cfg_data;
                ps2cas_pkg::REG_ENABLE:   r_cfg.enable_scan_cmd    <= i_cfg_data;
                ps2cas_pkg::REG_RESETCMD: r_cfg.reset_selftest_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/ps2cas_step.sv @@
module ps2cas_step #(
    parameter int ACK_TIMEOUT_MS       = ps2cas_pkg::ACK_TIMEOUT_MS_DEF,
    parameter int RESET_ACK_TIMEOUT_MS = ps2cas_pkg::RESET_ACK_TIMEOUT_MS_DEF,
    parameter int SELFTEST_TIMEOUT_MS  = ps2cas_pkg::SELFTEST_TIMEOUT_MS_DEF,
    parameter int MAX_RESENDS          = ps2cas_pkg::MAX_RESENDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic [1:0]        i_operation,
    input  logic [1:0]        i_port_number,
    input  logic [7:0]        i_rx_byte,
    input  ps2cas_pkg::t_cfg  i_cfg,
    output ps2cas_pkg::t_res  o_res0,
    output ps2cas_pkg::t_res  o_res1,
    output logic [1:0]        o_res_cnt
);

    localparam int EW = ps2cas_pkg::ELAPSED_W;
    localparam int RW = ps2cas_pkg::RESENDS_W;
    localparam logic [EW-1:0] LIM_ACK = EW'(ACK_TIMEOUT_MS);
    localparam logic [EW-1:0] LIM_RST = EW'(RESET_ACK_TIMEOUT_MS);
    localparam logic [EW-1:0] LIM_ST  = EW'(SELFTEST_TIMEOUT_MS);
    localparam logic [RW-1:0] RESENDS = RW'(MAX_RESENDS);

    ps2cas_pkg::t_phase  r_phase, n_phase;
    logic [1:0]          r_op, n_op;
    logic [1:0]          r_port, n_port;
    logic [RW-1:0]       r_rl, n_rl;
    logic [EW-1:0]       r_el, n_el;
    ps2cas_pkg::t_status r_saved, n_saved;

    logic                succ, fl, bg, wr, fin, fin_fdf;
    ps2cas_pkg::t_status fl_code, fin_st;
    ps2cas_pkg::t_phase  bg_ph, wr_ph;
    logic [EW-1:0]       el_inc, lim;
    logic [7:0]          cmd;
    logic                idle;

    assign idle   = (r_phase == ps2cas_pkg::PH_IDLE);
    assign el_inc = (r_el == ps2cas_pkg::ELAPSED_MAX) ? r_el : r_el + EW'(1);

    // Timeout limit of the current wait.
    always_comb begin
        lim = LIM_ACK;
        if (r_phase == ps2cas_pkg::PH_RST) begin
            lim = LIM_RST;
        end else if (r_phase == ps2cas_pkg::PH_SELFTEST) begin
            lim = LIM_ST;
        end
    end

    // Next state and results of one accepted word.
    always_comb begin
        n_phase = r_phase;
        n_op    = r_op;
        n_port  = r_port;
        n_rl    = r_rl;
        n_el    = r_el;
        n_saved = r_saved;
        succ    = 1'b0;
        fl      = 1'b0;
        fl_code = ps2cas_pkg::ST_OK;
        bg      = 1'b0;
        bg_ph   = ps2cas_pkg::PH_IDLE;
        wr      = 1'b0;
        fin     = 1'b0;
        fin_st  = ps2cas_pkg::ST_OK;
        fin_fdf = 1'b0;

        // Decode the event.
        if (i_accept) begin
            unique case (i_req_type)
                ps2cas_pkg::REQ_START: begin
                    if (idle) begin
                        if ((i_port_number != ps2cas_pkg::PORT_ONE &&
                             i_port_number != ps2cas_pkg::PORT_TWO) ||
                            i_operation > ps2cas_pkg::OP_RESET) begin
                            fin    = 1'b1;
                            fin_st = ps2cas_pkg::ST_BAD;
                        end else begin
                            n_op    = i_operation;
                            n_port  = i_port_number;
                            n_saved = ps2cas_pkg::ST_OK;
                            bg      = 1'b1;
                            bg_ph   = (i_operation == ps2cas_pkg::OP_ENABLE) ?
                                      ps2cas_pkg::PH_EN : ps2cas_pkg::PH_DIS1;
                        end
                    end
                end
                ps2cas_pkg::REQ_BYTE: begin
                    if (!idle) begin
                        n_el = '0;
                        if (r_phase == ps2cas_pkg::PH_DRAIN) begin
                            succ = 1'b0;
                        end else if (r_phase == ps2cas_pkg::PH_SELFTEST) begin
                            if (i_rx_byte == i_cfg.selftest_ok_code) begin
                                succ = 1'b1;
                            end else begin
                                fl      = 1'b1;
                                fl_code = ps2cas_pkg::ST_NODEV;
                            end
                        end else if (i_rx_byte == i_cfg.ack_code) begin
                            succ = 1'b1;
                        end else if (i_rx_byte == i_cfg.resend_code) begin
                            if (r_rl == '0) begin
                                fl      = 1'b1;
                                fl_code = ps2cas_pkg::ST_TIMEOUT;
                            end else begin
                                n_rl = r_rl - RW'(1);
                                wr   = 1'b1;
                            end
                        end else if (r_phase == ps2cas_pkg::PH_RST) begin
                            fl      = 1'b1;
                            fl_code = ps2cas_pkg::ST_NODEV;
                        end
                    end
                end
                ps2cas_pkg::REQ_TICK: begin
                    if (!idle) begin
                        n_el = el_inc;
                        if (el_inc >= lim) begin
                            fl      = 1'b1;
                            fl_code = ps2cas_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end

        // A wait that ended well.
        if (succ) begin
            unique case (r_phase)
                ps2cas_pkg::PH_DIS1: begin
                    if (r_op == ps2cas_pkg::OP_RESET) begin
                        bg    = 1'b1;
                        bg_ph = ps2cas_pkg::PH_RST;
                    end else begin
                        fin = 1'b1;
                    end
                end
                ps2cas_pkg::PH_EN: fin = 1'b1;
                ps2cas_pkg::PH_RST: begin
                    n_phase = ps2cas_pkg::PH_SELFTEST;
                    n_el    = '0;
                end
                ps2cas_pkg::PH_SELFTEST: begin
                    bg    = 1'b1;
                    bg_ph = ps2cas_pkg::PH_DIS2;
                end
                ps2cas_pkg::PH_DIS2: begin
                    n_phase = ps2cas_pkg::PH_DRAIN;
                    n_el    = '0;
                end
                ps2cas_pkg::PH_DIS3: begin
                    fin    = 1'b1;
                    fin_st = r_saved;
                end
                default: n_phase = ps2cas_pkg::PH_IDLE;
            endcase
        end

        // A wait that timed out or found no device.
        if (fl) begin
            unique case (r_phase)
                ps2cas_pkg::PH_DIS1: begin
                    if (r_op == ps2cas_pkg::OP_RESET) begin
                        n_saved = fl_code;
                        bg      = 1'b1;
                        bg_ph   = ps2cas_pkg::PH_DIS3;
                    end else begin
                        fin    = 1'b1;
                        fin_st = fl_code;
                    end
                end
                ps2cas_pkg::PH_EN: begin
                    fin    = 1'b1;
                    fin_st = fl_code;
                end
                ps2cas_pkg::PH_RST, ps2cas_pkg::PH_SELFTEST: begin
                    n_saved = fl_code;
                    bg      = 1'b1;
                    bg_ph   = ps2cas_pkg::PH_DIS3;
                end
                ps2cas_pkg::PH_DIS2: begin
                    n_phase = ps2cas_pkg::PH_DRAIN;
                    n_el    = '0;
                end
                ps2cas_pkg::PH_DRAIN: begin
                    bg    = 1'b1;
                    bg_ph = ps2cas_pkg::PH_DIS3;
                end
                ps2cas_pkg::PH_DIS3: begin
                    fin     = 1'b1;
                    fin_st  = r_saved;
                    fin_fdf = 1'b1;
                end
                default: n_phase = ps2cas_pkg::PH_IDLE;
            endcase
        end

        // Starting a new command restarts the retry budget.
        if (bg) begin
            n_phase = bg_ph;
            n_rl    = RESENDS;
            wr      = 1'b1;
        end
        if (wr) begin
            n_el = '0;
        end
        if (fin) begin
            n_phase = ps2cas_pkg::PH_IDLE;
        end
    end

    assign wr_ph = bg ? bg_ph : r_phase;

    // Device command byte for the phase being written.
    always_comb begin
        cmd = i_cfg.disable_scan_cmd;
        if (wr_ph == ps2cas_pkg::PH_EN) begin
            cmd = i_cfg.enable_scan_cmd;
        end else if (wr_ph == ps2cas_pkg::PH_RST) begin
            cmd = i_cfg.reset_selftest_cmd;
        end
    end

    // Result words: optional port-two prefix, then the command, or a finish.
    always_comb begin
        o_res0    = '{ps2cas_pkg::ACT_DONE, 8'd0, fin_st, fin_fdf, 1'b1};
        o_res1    = '{ps2cas_pkg::ACT_DATA, cmd, ps2cas_pkg::ST_OK, 1'b0, 1'b1};
        o_res_cnt = 2'd0;
        if (wr) begin
            if (n_port == ps2cas_pkg::PORT_TWO) begin
                o_res0 = '{ps2cas_pkg::ACT_CMD, i_cfg.second_port_prefix,
                           ps2cas_pkg::ST_OK, 1'b0, 1'b0};
                o_res_cnt = 2'd2;
            end else begin
                o_res0 = '{ps2cas_pkg::ACT_DATA, cmd, ps2cas_pkg::ST_OK, 1'b0, 1'b1};
                o_res_cnt = 2'd1;
            end
        end else if (fin) begin
            o_res_cnt = 2'd1;
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ps2cas_pkg::PH_IDLE;
            r_op    <= '0;
            r_port  <= '0;
            r_rl    <= '0;
            r_el    <= '0;
            r_saved <= ps2cas_pkg::ST_OK;
        end else begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_port  <= n_port;
            r_rl    <= n_rl;
            r_el    <= n_el;
            r_saved <= n_saved;
        end
    end

endmodule

@@ rtl/ps2cas_resq.sv @@
module ps2cas_resq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  ps2cas_pkg::t_res  i_push0,
    input  ps2cas_pkg::t_res  i_push1,
    input  logic              i_pop,
    output ps2cas_pkg::t_res  o_head,
    output logic              o_valid,
    output logic              o_stall
);

    localparam int DEPTH = ps2cas_pkg::RESQ_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ps2cas_pkg::t_res r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    // Keep room for the two words one item can cause.
    assign o_stall = (r_count > CW'(DEPTH - 2));

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wptr + AW'(1)] <= i_push1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + AW'(i_push_cnt);
            r_rptr  <= r_rptr + AW'(pop);
            r_count <= r_count + CW'(i_push_cnt) - CW'(pop);
        end
    end

endmodule

@@ rtl/ps2cas_checker.sv @@
`include "assert_macros.svh"

module ps2cas_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_req_type,
    input logic [1:0] i_operation,
    input logic [1:0] i_port_number,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_action,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_status,
    input logic       o_final_disable_failed,
    input logic       o_last,
    input logic       i_cfg_we,
    input logic [2:0] i_cfg_idx,
    input logic [7:0] i_cfg_data
);

    // A stalled result word stays offered.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid)

    // Reset empties the result queue.
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // An empty queue never stalls the input.
    `ASSERT_CLK(a_no_idle_stall, i_clk, i_rst_n, !o_out_valid |-> !o_in_stall)

    // A finish word closes its item and carries no byte.
    `ASSERT_CLK(a_done_form, i_clk, i_rst_n,
        (o_out_valid && o_action == ps2cas_pkg::ACT_DONE) |-> (o_last && o_out_byte == 8'd0))

    // A port-two prefix is always followed by its command word.
    `ASSERT_CLK(a_prefix_not_last, i_clk, i_rst_n,
        (o_out_valid && o_action == ps2cas_pkg::ACT_CMD) |-> !o_last)

endmodule

bind ps2_command_ack_sequencer_unit ps2cas_checker u_checker (.*);
